// ----- rtl/ratalu_pkg.sv -----
// Shared types and constants of the rational number ALU.
package ratalu_pkg;

  // Field widths of the channels and of the internal wide datapath
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 31;
  localparam int WIDE_W    = 64;
  localparam int WIDTH_DEF = 32;
  localparam int SHIFT_W   = $clog2(WIDE_W) + 1;

  // Operation codes on the in_kind port
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CMP,
    OP_DZ,
    OP_NONE
  } op_t;

  // One classified item: operation and both operands as sign and magnitude
  typedef struct packed {
    op_t              op;
    logic             sa;
    logic [NUM_W-1:0] ma;
    logic [DEN_W-1:0] da;
    logic             sb;
    logic [NUM_W-1:0] mb;
    logic [DEN_W-1:0] db;
  } item_t;

  // Back end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NA_GCD,
    ST_NA_GWAIT,
    ST_NA_DIV,
    ST_NA_DWAIT,
    ST_NB_GCD,
    ST_NB_GWAIT,
    ST_NB_DIV,
    ST_NB_DWAIT,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_R_GCD,
    ST_R_GWAIT,
    ST_R_DIV,
    ST_R_DWAIT,
    ST_FIN
  } st_t;

endpackage

// ----- rtl/rational_number_alu_top.sv -----
// Top level of the rational number ALU.
//
// Input channel (in_valid / in_stall): one item is an operation code and two
// fractions a_num/a_den and b_num/b_den, transferred when in_valid is high and
// in_stall is low. Result channel (out_valid / out_stall): one result per item,
// the reduced fraction result_num/result_den plus compare and error flags.
// Operation codes: 0 add, 1 subtract, 2 multiply, 3 divide, 4 compare;
// other codes give 0/1 with every flag low.
// The front end registers and classifies each item and pushes it into a
// two-entry queue, so up to three items can be taken while the back end works.
// The back end handles one item at a time. Per item it runs a binary gcd (one
// step per cycle) and the divider once for each operand and, except for
// compare, once for the result, plus 32x32 multiplies in states ST_MUL1 to
// ST_MUL3; unused codes and divide by zero skip all of these steps.
// Reset (synchronous, rst_n low) empties the queue and the output register.
// A stalled result holds in the output register; the back end then waits
// at its finish step and the queue fills before in_stall rises.
module rational_number_alu_top #(
  parameter int WIDTH = ratalu_pkg::WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_kind,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_a_num,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_a_den,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_b_num,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_b_den,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ratalu_pkg::NUM_W-1:0] out_result_num,
  output logic [ratalu_pkg::DEN_W-1:0]        out_result_den,
  output logic                                out_greater,
  output logic                                out_equal,
  output logic                                out_less,
  output logic                                out_div_by_zero,
  output logic                                out_overflow
);
  import ratalu_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  item_t push_item, pop_item;

  ratalu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  ratalu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  ratalu_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_num  (out_result_num),
    .out_result_den  (out_result_den),
    .out_greater     (out_greater),
    .out_equal       (out_equal),
    .out_less        (out_less),
    .out_div_by_zero (out_div_by_zero),
    .out_overflow    (out_overflow)
  );

endmodule

// ----- rtl/ratalu_front.sv -----
// Front end: accept an item, classify it and split operands into sign and magnitude.
module ratalu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_kind,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_a_num,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_a_den,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_b_num,
  input  logic signed [ratalu_pkg::NUM_W-1:0] in_b_den,
  input  logic                          q_full,
  output logic                          q_push,
  output ratalu_pkg::item_t             q_item
);
  import ratalu_pkg::*;

  logic  fv_r;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  // Hold the item while the queue is full
  assign in_stall = fv_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = fv_r & ~q_full;
  assign q_item   = item_r;

  // Classify the operation and fix bad denominators
  always_comb begin
    item_nxt.sa = in_a_num[NUM_W-1];
    item_nxt.ma = in_a_num[NUM_W-1] ? (~in_a_num + 1'b1) : in_a_num;
    item_nxt.da = (in_a_den[NUM_W-1] || in_a_den == '0) ? DEN_W'(1) : in_a_den[DEN_W-1:0];
    item_nxt.sb = in_b_num[NUM_W-1];
    item_nxt.mb = in_b_num[NUM_W-1] ? (~in_b_num + 1'b1) : in_b_num;
    item_nxt.db = (in_b_den[NUM_W-1] || in_b_den == '0) ? DEN_W'(1) : in_b_den[DEN_W-1:0];
    case (in_kind)
      KIND_ADD: item_nxt.op = OP_ADD;
      KIND_SUB: item_nxt.op = OP_SUB;
      KIND_MUL: item_nxt.op = OP_MUL;
      KIND_DIV: item_nxt.op = (in_b_num == '0) ? OP_DZ : OP_DIV;
      KIND_CMP: item_nxt.op = OP_CMP;
      default:  item_nxt.op = OP_NONE;
    endcase
  end

  // Advance the front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= 1'b1;
    end else if (q_push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/ratalu_queue.sv -----
// Two-entry queue between the front end and the back end.
module ratalu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ratalu_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output ratalu_pkg::item_t pop_item,
  output logic              empty
);
  import ratalu_pkg::*;

  item_t       mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_item = mem_r[rp_r];

  // Write the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/ratalu_gcd.sv -----
// Binary gcd unit on the wide datapath, one step per cycle.
module ratalu_gcd (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ratalu_pkg::WIDE_W-1:0]  x,
  input  logic [ratalu_pkg::WIDE_W-1:0]  y,
  output logic                           busy,
  output logic [ratalu_pkg::WIDE_W-1:0]  g
);
  import ratalu_pkg::*;

  logic [WIDE_W-1:0]  x_r;
  logic [WIDE_W-1:0]  y_r;
  logic [SHIFT_W-1:0] k_r;
  logic               odd_r;
  logic               busy_r;
  logic [WIDE_W-1:0]  g_r;

  assign busy = busy_r;
  assign g    = g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (x_r == '0 || y_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  // Strip common factors of two, then subtract and halve
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      k_r   <= '0;
      odd_r <= 1'b0;
    end else if (busy_r) begin
      if (x_r == '0) begin
        g_r <= y_r << k_r;
      end else if (y_r == '0) begin
        g_r <= x_r << k_r;
      end else if (!odd_r) begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else begin
          odd_r <= 1'b1;
        end
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= (x_r - y_r) >> 1;
      end else begin
        y_r <= (y_r - x_r) >> 1;
      end
    end
  end

endmodule

// ----- rtl/ratalu_div.sv -----
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module ratalu_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ratalu_pkg::WIDE_W-1:0]  n0,
  input  logic [ratalu_pkg::WIDE_W-1:0]  n1,
  input  logic [ratalu_pkg::WIDE_W-1:0]  dv,
  output logic                           busy,
  output logic [ratalu_pkg::WIDE_W-1:0]  q0,
  output logic [ratalu_pkg::WIDE_W-1:0]  q1
);
  import ratalu_pkg::*;

  logic [WIDE_W-1:0]  q0_r;
  logic [WIDE_W-1:0]  q1_r;
  logic [WIDE_W-1:0]  r0_r;
  logic [WIDE_W-1:0]  r1_r;
  logic [WIDE_W-1:0]  dv_r;
  logic [SHIFT_W-1:0] cnt_r;
  logic               busy_r;
  logic [WIDE_W:0]    t0;
  logic [WIDE_W:0]    t1;
  logic               b0;
  logic               b1;

  assign busy = busy_r;
  assign q0   = q0_r;
  assign q1   = q1_r;

  // Trial subtract on both lanes
  always_comb begin
    t0 = {r0_r, q0_r[WIDE_W-1]};
    t1 = {r1_r, q1_r[WIDE_W-1]};
    b0 = t0 >= {1'b0, dv_r};
    b1 = t1 >= {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q0_r  <= n0;
      q1_r  <= n1;
      r0_r  <= '0;
      r1_r  <= '0;
      dv_r  <= dv;
      cnt_r <= SHIFT_W'(WIDE_W - 1);
    end else if (busy_r) begin
      q0_r  <= {q0_r[WIDE_W-2:0], b0};
      q1_r  <= {q1_r[WIDE_W-2:0], b1};
      r0_r  <= b0 ? WIDE_W'(t0 - {1'b0, dv_r}) : t0[WIDE_W-1:0];
      r1_r  <= b1 ? WIDE_W'(t1 - {1'b0, dv_r}) : t1[WIDE_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- rtl/ratalu_back.sv -----
// Back end: normalize operands, form the result, reduce it and hold it for the output.
module ratalu_back #(
  parameter int WIDTH = ratalu_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  ratalu_pkg::item_t                  q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ratalu_pkg::NUM_W-1:0] out_result_num,
  output logic [ratalu_pkg::DEN_W-1:0]       out_result_den,
  output logic                               out_greater,
  output logic                               out_equal,
  output logic                               out_less,
  output logic                               out_div_by_zero,
  output logic                               out_overflow
);
  import ratalu_pkg::*;

  localparam logic [WIDE_W-1:0] LO_MAG = WIDE_W'(1) << (WIDTH - 1);
  localparam logic [WIDE_W-1:0] HI     = LO_MAG - WIDE_W'(1);

  st_t state_r, state_nxt;

  // Operand and intermediate registers
  op_t               op_r;
  logic              sa_r, sb_r;
  logic [NUM_W-1:0]  ma_r, mb_r;
  logic [DEN_W-1:0]  da_r, db_r;
  logic [WIDE_W-1:0] p1_r, p2_r, p3_r;
  logic              neg_r;
  logic [WIDE_W-1:0] rm_r, rd_r;
  logic              gt_r, eq_r, lt_r;

  // Output register
  logic [NUM_W-1:0]  onum_r;
  logic [DEN_W-1:0]  oden_r;
  logic              ogt_r, oeq_r, olt_r, odz_r, oov_r;

  // Shared unit connections
  logic              g_start, d_start;
  logic [WIDE_W-1:0] gx, gy, gres;
  logic              g_busy, d_busy;
  logic [WIDE_W-1:0] dn0, dn1, dq0, dq1;
  logic [NUM_W-1:0]  mul_a, mul_b;
  logic [WIDE_W-1:0] prod;
  logic              out_free;

  // Combine step
  logic signed [WIDE_W:0] ls, rs, sum;
  logic                   c_neg;
  logic [WIDE_W-1:0]      c_mag, c_den;

  // Final result
  logic              f_ov;
  logic [NUM_W-1:0]  f_num;

  ratalu_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (g_start),
    .x     (gx),
    .y     (gy),
    .busy  (g_busy),
    .g     (gres)
  );

  ratalu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d_start),
    .n0    (dn0),
    .n1    (dn1),
    .dv    (gres),
    .busy  (d_busy),
    .q0    (dq0),
    .q1    (dq1)
  );

  assign out_free        = ~out_valid | ~out_stall;
  assign out_result_num  = onum_r;
  assign out_result_den  = oden_r;
  assign out_greater     = ogt_r;
  assign out_equal       = oeq_r;
  assign out_less        = olt_r;
  assign out_div_by_zero = odz_r;
  assign out_overflow    = oov_r;

  // Select operands of the gcd, divider and multiplier
  always_comb begin
    case (state_r)
      ST_NA_GCD, ST_NA_DIV: begin
        gx = {{(WIDE_W-NUM_W){1'b0}}, ma_r};
        gy = {{(WIDE_W-DEN_W){1'b0}}, da_r};
      end
      ST_NB_GCD, ST_NB_DIV: begin
        gx = {{(WIDE_W-NUM_W){1'b0}}, mb_r};
        gy = {{(WIDE_W-DEN_W){1'b0}}, db_r};
      end
      default: begin
        gx = rm_r;
        gy = rd_r;
      end
    endcase
    dn0 = gx;
    dn1 = gy;
    case (state_r)
      ST_MUL1: begin
        mul_a = ma_r;
        mul_b = (op_r == OP_MUL) ? mb_r : {1'b0, db_r};
      end
      ST_MUL2: begin
        mul_a = {1'b0, da_r};
        mul_b = mb_r;
      end
      default: begin
        mul_a = {1'b0, da_r};
        mul_b = {1'b0, db_r};
      end
    endcase
    prod = WIDE_W'(mul_a) * WIDE_W'(mul_b);
  end

  // Form the unreduced result from the products
  always_comb begin
    ls  = sa_r ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r});
    rs  = sb_r ? -$signed({1'b0, p2_r}) : $signed({1'b0, p2_r});
    sum = (op_r == OP_SUB) ? (ls - rs) : (ls + rs);
    case (op_r)
      OP_ADD, OP_SUB: begin
        c_neg = sum[WIDE_W];
        c_mag = sum[WIDE_W] ? WIDE_W'(-sum) : sum[WIDE_W-1:0];
        c_den = p3_r;
      end
      OP_MUL: begin
        c_neg = sa_r ^ sb_r;
        c_mag = p1_r;
        c_den = p3_r;
      end
      default: begin
        c_neg = sa_r ^ sb_r;
        c_mag = p1_r;
        c_den = p2_r;
      end
    endcase
  end

  // Range check and sign of the reduced result
  always_comb begin
    f_ov  = (neg_r ? (rm_r > LO_MAG) : (rm_r > HI)) || (rd_r > HI);
    f_num = neg_r ? NUM_W'(-rm_r) : rm_r[NUM_W-1:0];
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Step through normalize, multiply, combine, reduce
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    g_start   = 1'b0;
    d_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.op == OP_NONE || q_item.op == OP_DZ) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_NA_GCD;
          end
        end
      end
      ST_NA_GCD: begin
        g_start   = 1'b1;
        state_nxt = ST_NA_GWAIT;
      end
      ST_NA_GWAIT: if (!g_busy) state_nxt = ST_NA_DIV;
      ST_NA_DIV: begin
        d_start   = 1'b1;
        state_nxt = ST_NA_DWAIT;
      end
      ST_NA_DWAIT: if (!d_busy) state_nxt = ST_NB_GCD;
      ST_NB_GCD: begin
        g_start   = 1'b1;
        state_nxt = ST_NB_GWAIT;
      end
      ST_NB_GWAIT: if (!g_busy) state_nxt = ST_NB_DIV;
      ST_NB_DIV: begin
        d_start   = 1'b1;
        state_nxt = ST_NB_DWAIT;
      end
      ST_NB_DWAIT: if (!d_busy) state_nxt = ST_MUL1;
      ST_MUL1:     state_nxt = ST_MUL2;
      ST_MUL2:     state_nxt = ST_MUL3;
      ST_MUL3:     state_nxt = ST_COMB;
      ST_COMB:     state_nxt = (op_r == OP_CMP) ? ST_FIN : ST_R_GCD;
      ST_R_GCD: begin
        g_start   = 1'b1;
        state_nxt = ST_R_GWAIT;
      end
      ST_R_GWAIT: if (!g_busy) state_nxt = ST_R_DIV;
      ST_R_DIV: begin
        d_start   = 1'b1;
        state_nxt = ST_R_DWAIT;
      end
      ST_R_DWAIT: if (!d_busy) state_nxt = ST_FIN;
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Load operands and intermediate results
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_item.op;
      sa_r <= q_item.sa;
      ma_r <= q_item.ma;
      da_r <= q_item.da;
      sb_r <= q_item.sb;
      mb_r <= q_item.mb;
      db_r <= q_item.db;
    end
    if (state_r == ST_NA_DWAIT && !d_busy) begin
      ma_r <= dq0[NUM_W-1:0];
      da_r <= dq1[DEN_W-1:0];
    end
    if (state_r == ST_NB_DWAIT && !d_busy) begin
      mb_r <= dq0[NUM_W-1:0];
      db_r <= dq1[DEN_W-1:0];
    end
    if (state_r == ST_MUL1) p1_r <= prod;
    if (state_r == ST_MUL2) p2_r <= prod;
    if (state_r == ST_MUL3) p3_r <= prod;
    if (state_r == ST_COMB) begin
      neg_r <= c_neg;
      rm_r  <= c_mag;
      rd_r  <= c_den;
      gt_r  <= ls > rs;
      eq_r  <= ls == rs;
      lt_r  <= ls < rs;
    end
    if (state_r == ST_R_DWAIT && !d_busy) begin
      rm_r <= dq0;
      rd_r <= dq1;
    end
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      onum_r <= '0;
      oden_r <= DEN_W'(1);
      ogt_r  <= 1'b0;
      oeq_r  <= 1'b0;
      olt_r  <= 1'b0;
      odz_r  <= 1'b0;
      oov_r  <= 1'b0;
      case (op_r)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          oov_r <= f_ov;
          if (!f_ov) begin
            onum_r <= f_num;
            oden_r <= rd_r[DEN_W-1:0];
          end
        end
        OP_CMP: begin
          ogt_r <= gt_r;
          oeq_r <= eq_r;
          olt_r <= lt_r;
        end
        OP_DZ:   odz_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ratalu_checker.sv -----
// Port-level checks of the rational number ALU and their binding to the top level.
module ratalu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [ratalu_pkg::NUM_W-1:0] out_result_num,
  input logic [ratalu_pkg::DEN_W-1:0]        out_result_den,
  input logic                                out_greater,
  input logic                                out_equal,
  input logic                                out_less,
  input logic                                out_div_by_zero,
  input logic                                out_overflow
);
  import ratalu_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Compare raises at most one outcome and gives 0/1
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_greater || out_equal || out_less) |->
      $onehot({out_greater, out_equal, out_less}) && out_result_num == 0 &&
      out_result_den == 1 && !out_overflow && !out_div_by_zero)
    else $error("bad compare result");

  // Divide by zero and overflow force 0/1 and exclude each other
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_div_by_zero || out_overflow) |->
      out_result_num == 0 && out_result_den == 1 &&
      !(out_div_by_zero && out_overflow))
    else $error("bad error result");

  // Denominator is never zero
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_den != 0)
    else $error("zero denominator");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_num) &&
      $stable(out_result_den))
    else $error("stalled result changed");

endmodule

bind rational_number_alu_top ratalu_checker u_ratalu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_num  (out_result_num),
  .out_result_den  (out_result_den),
  .out_greater     (out_greater),
  .out_equal       (out_equal),
  .out_less        (out_less),
  .out_div_by_zero (out_div_by_zero),
  .out_overflow    (out_overflow)
);
